FILE: design/ted_pkg.sv
// Shared types, codes and a helper function for the text encoding detector.
package ted_pkg;

    // Result codes for the classification.
    typedef enum logic [2:0] {
        CLASS_ANSI     = 3'd0,
        CLASS_UTF8     = 3'd1,
        CLASS_UTF8_BOM = 3'd2,
        CLASS_UTF16_LE = 3'd3,
        CLASS_UTF16_BE = 3'd4
    } enc_class_t;

    // Byte-order marks as seen in the first two bytes.
    localparam logic [15:0] BOM_UTF16_LE = 16'hFFFE;
    localparam logic [15:0] BOM_UTF16_BE = 16'hFEFF;
    localparam logic [15:0] BOM_UTF8     = 16'hEFBB;

    // Saturation point of the byte counter.
    localparam logic [1:0] HEADER_LEN = 2'd2;

    // Per-stream tracking state.
    typedef struct packed {
        logic [2:0]  pending;
        logic        all_ascii;
        logic        broken;
        logic [15:0] header;
        logic [1:0]  seen;
    } trk_state_t;

    localparam trk_state_t TRK_RESET = '{
        pending:   3'd0,
        all_ascii: 1'b1,
        broken:    1'b0,
        header:    16'h0000,
        seen:      2'd0
    };

    // Continuation bytes that follow a lead byte; zero for an ASCII byte or a stray continuation.
    function automatic logic [2:0] lead_follow_count(input logic [7:0] b);
        logic [2:0] n;
        if (b == 8'hFC || b == 8'hFD) begin
            n = 3'd5;
        end else if (b >= 8'hF8) begin
            n = 3'd4;
        end else if (b >= 8'hF0) begin
            n = 3'd3;
        end else if (b >= 8'hE0) begin
            n = 3'd2;
        end else if (b >= 8'hC0) begin
            n = 3'd1;
        end else begin
            n = 3'd0;
        end
        return n;
    endfunction

endpackage

FILE: design/ted_step.sv
// Per-byte state update and classification of the stream seen so far.
module ted_step (
    input  ted_pkg::trk_state_t state_cur,
    input  logic [7:0]          data_byte,
    output ted_pkg::trk_state_t state_upd,
    output ted_pkg::enc_class_t enc_class
);

    logic [2:0] follow;

    assign follow = ted_pkg::lead_follow_count(data_byte);

    // Header capture and UTF-8 sequence tracking.
    always_comb begin
        state_upd = state_cur;
        if (state_cur.seen == 2'd0) begin
            state_upd.header = {data_byte, 8'h00};
            state_upd.seen   = 2'd1;
        end else if (state_cur.seen == 2'd1) begin
            state_upd.header = {state_cur.header[15:8], data_byte};
            state_upd.seen   = ted_pkg::HEADER_LEN;
        end
        if (data_byte[7]) begin
            state_upd.all_ascii = 1'b0;
        end
        if (!state_cur.broken) begin
            if (state_cur.pending == 3'd0) begin
                if (data_byte[7]) begin
                    if (follow == 3'd0) begin
                        state_upd.broken = 1'b1;
                    end else begin
                        state_upd.pending = follow;
                    end
                end
            end else begin
                if (data_byte[7:6] != 2'b10) begin
                    state_upd.broken = 1'b1;
                end else begin
                    state_upd.pending = state_cur.pending - 3'd1;
                end
            end
        end
    end

    // Classification of the updated state.
    always_comb begin
        if (state_upd.seen != ted_pkg::HEADER_LEN) begin
            enc_class = ted_pkg::CLASS_ANSI;
        end else if (state_upd.header == ted_pkg::BOM_UTF16_LE) begin
            enc_class = ted_pkg::CLASS_UTF16_LE;
        end else if (state_upd.header == ted_pkg::BOM_UTF16_BE) begin
            enc_class = ted_pkg::CLASS_UTF16_BE;
        end else if (state_upd.header == ted_pkg::BOM_UTF8) begin
            enc_class = ted_pkg::CLASS_UTF8_BOM;
        end else if (state_upd.broken || state_upd.pending != 3'd0 || state_upd.all_ascii) begin
            enc_class = ted_pkg::CLASS_ANSI;
        end else begin
            enc_class = ted_pkg::CLASS_UTF8;
        end
    end

endmodule

FILE: design/text_encoding_detector.sv
// Text encoding detector: byte stream in, one classification per stream out.
// Structure: a byte is registered at input, processed by the tracking update, and
// the result of a final byte is captured in the result register that drives m_valid.
// Throughput: one byte per cycle, but a final byte waits while an untaken result is held.
// Reset: synchronous active-low aresetn clears valids and the tracking state.
module text_encoding_detector (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_end_of_text,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_encoding_class
);

    logic                in_vld_reg;
    logic [7:0]          byte_reg;
    logic                last_reg;
    ted_pkg::trk_state_t state_reg;
    ted_pkg::trk_state_t state_next;
    ted_pkg::trk_state_t state_upd;
    ted_pkg::enc_class_t class_comb;
    logic                out_vld_reg;
    logic [2:0]          class_reg;
    logic                advance;

    // A byte moves on unless it is final and the result register is still held.
    assign advance = in_vld_reg && (!last_reg || !out_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || advance;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            byte_reg <= s_data_byte;
            last_reg <= s_end_of_text;
        end
    end

    ted_step u_step (
        .state_cur (state_reg),
        .data_byte (byte_reg),
        .state_upd (state_upd),
        .enc_class (class_comb)
    );

    // Tracking state: updated by each byte that moves on, cleared after the final byte of a stream.
    always_comb begin
        state_next = state_reg;
        if (advance) begin
            state_next = last_reg ? ted_pkg::TRK_RESET : state_upd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ted_pkg::TRK_RESET;
        end else begin
            state_reg <= state_next;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (advance && last_reg) begin
            out_vld_reg <= 1'b1;
        end else if (m_ready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && last_reg) begin
            class_reg <= class_comb;
        end
    end

    assign m_valid          = out_vld_reg;
    assign m_encoding_class = class_reg;

    // A final byte never overwrites a result that has not been taken.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && last_reg) |-> (!out_vld_reg || m_ready))
        else $error("result overwritten before transaction completed");

    // The stream state starts over after a final byte.
    a_state_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && last_reg) |=> (state_reg.seen == 2'd0 && state_reg.pending == 3'd0))
        else $error("tracking state not cleared after end of text");

    // Pending continuation count never exceeds the longest sequence.
    a_pending_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.pending <= 3'd5)
        else $error("pending continuation count out of range");

    // A held result keeps a defined class code.
    a_class_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_encoding_class <= 3'd4))
        else $error("result class out of range");

endmodule
